// ===== rtl/uld_pkg.sv =====
`default_nettype none

package uld_pkg;

  localparam int LINE_CHARS_DEF = 64;
  localparam int RAW_DEPTH_DEF  = 128;
  localparam int QUEUE_DEPTH    = 2;
  localparam int ERASE_LEN      = 7;

  localparam logic [7:0] CHAR_BS  = 8'd127;
  localparam logic [7:0] CHAR_CR  = 8'd13;
  localparam logic [7:0] CHAR_LF  = 8'd10;
  localparam logic [7:0] CHAR_TAB = 8'd9;
  localparam logic [7:0] CHAR_ESC = 8'd27;

  typedef enum logic [2:0] {
    CMD_RAW_PUSH,
    CMD_RAW_POP,
    CMD_READ,
    CMD_ERASE,
    CMD_STORE
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_ECHO = 2'd0,
    KIND_DATA = 2'd1,
    KIND_NONE = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_EXEC,
    B_RAW_SEND,
    B_LINE_SEND,
    B_ERASE_SEND
  } back_state_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] data;
  } q_entry_t;

  function automatic logic [7:0] erase_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = CHAR_ESC;
      3'd1:    c = 8'h5B;
      3'd2:    c = 8'h31;
      3'd3:    c = 8'h44;
      3'd4:    c = CHAR_ESC;
      3'd5:    c = 8'h5B;
      3'd6:    c = 8'h4A;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/uld_ram.sv =====
`default_nettype none

module uld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/uld_front.sv =====
`default_nettype none

module uld_front
  import uld_pkg::*;
(
  input  wire logic       raw_en,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,
  input  wire logic [0:0] in_tuser,
  input  wire logic       q_full,
  output logic            q_push,
  output q_entry_t        q_entry
);

  logic drop;

  always_comb begin
    drop          = 1'b0;
    q_entry.data  = in_tdata;
    q_entry.cmd   = CMD_STORE;
    if (raw_en) begin
      q_entry.cmd = in_tuser[0] ? CMD_RAW_POP : CMD_RAW_PUSH;
    end else if (in_tuser[0]) begin
      q_entry.cmd = CMD_READ;
    end else begin
      case (in_tdata)
        CHAR_TAB: drop = 1'b1;
        CHAR_BS:  q_entry.cmd = CMD_ERASE;
        CHAR_CR:  q_entry.data = CHAR_LF;
        default:  q_entry.cmd = CMD_STORE;
      endcase
    end
  end

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full && !drop;

endmodule

`default_nettype wire

// ===== rtl/uld_queue.sv =====
`default_nettype none

module uld_queue
  import uld_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire q_entry_t push_entry,
  output logic          full,
  input  wire logic     pop,
  output logic          not_empty,
  output q_entry_t      head
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  q_entry_t        entry_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign full      = (count_r == CW'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = entry_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(wr_ptr_r + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(rd_ptr_r + 1'b1);
    end
    if (do_push && !do_pop) begin
      count_nxt = CW'(count_r + 1'b1);
    end else if (do_pop && !do_push) begin
      count_nxt = CW'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/uld_back.sv =====
`default_nettype none

module uld_back
  import uld_pkg::*;
#(
  parameter int LINE_CHARS = LINE_CHARS_DEF,
  parameter int RAW_DEPTH  = RAW_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wr,
  input  wire logic       cfg_raw,
  output logic            raw_en,
  input  wire logic       q_valid,
  input  wire q_entry_t   q_head,
  output logic            q_pop,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,
  output logic [1:0]      out_tuser,
  output logic            out_tlast
);

  localparam int IW = $clog2(LINE_CHARS);
  localparam int LRAM_DEPTH = 2 ** (IW + 1);
  localparam int RW = $clog2(RAW_DEPTH);

  back_state_t                     state_r, state_nxt;
  cmd_t                            cmd_r, cmd_nxt;
  logic [7:0]                      byte_r, byte_nxt;
  logic [IW-1:0]                   cursor_r, cursor_nxt;
  logic                            bank_r, bank_nxt;
  logic [1:0][LINE_CHARS-1:0]      valid_r, valid_nxt;
  logic [IW-1:0]                   idx_r, idx_nxt;
  logic [2:0]                      ecnt_r, ecnt_nxt;
  logic [RW-1:0]                   wp_r, wp_nxt;
  logic [RW-1:0]                   rp_r, rp_nxt;
  logic                            raw_en_r, raw_en_nxt;

  logic                            out_valid_r, out_valid_nxt;
  kind_t                           out_kind_r, out_kind_nxt;
  logic [7:0]                      out_byte_r, out_byte_nxt;
  logic                            out_last_r, out_last_nxt;

  logic                            eb, lb, out_free;
  logic [IW-1:0]                   cur_inc, cur_dec, idx_inc;
  logic [RW-1:0]                   wp_inc, rp_inc;
  logic                            raw_empty, raw_full, line_empty, line_last, erase_last;

  logic                            emit, emit_last;
  kind_t                           emit_kind;
  logic [7:0]                      emit_byte;

  logic                            lram_wr_en, lram_rd_en;
  logic [IW:0]                     lram_wr_addr, lram_rd_addr;
  logic [7:0]                      lram_rd_data;
  logic                            rram_wr_en, rram_rd_en;
  logic [RW-1:0]                   rram_rd_addr;
  logic [7:0]                      rram_rd_data;

  assign eb         = bank_r;
  assign lb         = ~bank_r;
  assign out_free   = !out_valid_r || out_tready;
  assign cur_inc    = IW'(cursor_r + 1'b1);
  assign cur_dec    = IW'(cursor_r - 1'b1);
  assign idx_inc    = IW'(idx_r + 1'b1);
  assign wp_inc     = (wp_r == RW'(RAW_DEPTH - 1)) ? '0 : RW'(wp_r + 1'b1);
  assign rp_inc     = (rp_r == RW'(RAW_DEPTH - 1)) ? '0 : RW'(rp_r + 1'b1);
  assign raw_empty  = (rp_r == wp_r);
  assign raw_full   = (wp_inc == rp_r);
  assign line_empty = !valid_r[lb][0];
  assign line_last  = (idx_r == IW'(LINE_CHARS - 2)) || !valid_r[lb][idx_inc];
  assign erase_last = (ecnt_r == 3'(ERASE_LEN - 1));

  uld_ram #(.WIDTH(8), .DEPTH(LRAM_DEPTH)) u_line_ram (
    .clk     (clk),
    .wr_en   (lram_wr_en),
    .wr_addr (lram_wr_addr),
    .wr_data (byte_r),
    .rd_en   (lram_rd_en),
    .rd_addr (lram_rd_addr),
    .rd_data (lram_rd_data)
  );

  uld_ram #(.WIDTH(8), .DEPTH(RAW_DEPTH)) u_raw_ram (
    .clk     (clk),
    .wr_en   (rram_wr_en),
    .wr_addr (wp_r),
    .wr_data (byte_r),
    .rd_en   (rram_rd_en),
    .rd_addr (rram_rd_addr),
    .rd_data (rram_rd_data)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          state_nxt = B_EXEC;
        end
      end
      B_EXEC: begin
        case (cmd_r)
          CMD_RAW_POP: begin
            if (!raw_empty) begin
              state_nxt = B_RAW_SEND;
            end else if (out_free) begin
              state_nxt = B_IDLE;
            end
          end
          CMD_READ: begin
            if (!line_empty) begin
              state_nxt = B_LINE_SEND;
            end else if (out_free) begin
              state_nxt = B_IDLE;
            end
          end
          CMD_ERASE: state_nxt = (cursor_r != '0) ? B_ERASE_SEND : B_IDLE;
          CMD_STORE: begin
            if (byte_r == 8'd0 || out_free) begin
              state_nxt = B_IDLE;
            end
          end
          default: state_nxt = B_IDLE;
        endcase
      end
      B_RAW_SEND: begin
        if (out_free) begin
          state_nxt = B_IDLE;
        end
      end
      B_LINE_SEND: begin
        if (out_free && line_last) begin
          state_nxt = B_IDLE;
        end
      end
      B_ERASE_SEND: begin
        if (out_free && erase_last) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    cmd_nxt      = cmd_r;
    byte_nxt     = byte_r;
    cursor_nxt   = cursor_r;
    bank_nxt     = bank_r;
    valid_nxt    = valid_r;
    idx_nxt      = idx_r;
    ecnt_nxt     = ecnt_r;
    wp_nxt       = wp_r;
    rp_nxt       = rp_r;
    raw_en_nxt   = raw_en_r;
    q_pop        = 1'b0;
    emit         = 1'b0;
    emit_kind    = KIND_ECHO;
    emit_byte    = 8'd0;
    emit_last    = 1'b0;
    lram_wr_en   = 1'b0;
    lram_wr_addr = {eb, cursor_r};
    lram_rd_en   = 1'b0;
    lram_rd_addr = {lb, idx_inc};
    rram_wr_en   = 1'b0;
    rram_rd_en   = 1'b0;
    rram_rd_addr = rp_r;

    case (state_r)
      B_IDLE: begin
        q_pop = q_valid;
        if (q_valid) begin
          cmd_nxt  = q_head.cmd;
          byte_nxt = q_head.data;
        end
      end
      B_EXEC: begin
        case (cmd_r)
          CMD_RAW_PUSH: begin
            if (!raw_full) begin
              rram_wr_en = 1'b1;
              wp_nxt     = wp_inc;
            end
          end
          CMD_RAW_POP: begin
            if (!raw_empty) begin
              rram_rd_en = 1'b1;
            end else if (out_free) begin
              emit      = 1'b1;
              emit_kind = KIND_NONE;
              emit_last = 1'b1;
            end
          end
          CMD_READ: begin
            if (!line_empty) begin
              lram_rd_en   = 1'b1;
              lram_rd_addr = {lb, IW'(0)};
              idx_nxt      = '0;
            end else if (out_free) begin
              emit          = 1'b1;
              emit_kind     = KIND_NONE;
              emit_last     = 1'b1;
              valid_nxt[lb] = '0;
            end
          end
          CMD_ERASE: begin
            if (cursor_r != '0) begin
              cursor_nxt             = cur_dec;
              valid_nxt[eb][cur_dec] = 1'b0;
              ecnt_nxt               = '0;
            end
          end
          CMD_STORE: begin
            if (byte_r == 8'd0 || out_free) begin
              if (byte_r != 8'd0) begin
                lram_wr_en              = 1'b1;
                valid_nxt[eb][cursor_r] = 1'b1;
                emit                    = 1'b1;
                emit_byte               = byte_r;
                emit_last               = 1'b1;
              end else begin
                valid_nxt[eb][cursor_r] = 1'b0;
              end
              if (byte_r == CHAR_LF) begin
                valid_nxt[eb][cur_inc] = 1'b0;
                valid_nxt[lb]          = '0;
                bank_nxt               = ~bank_r;
                cursor_nxt             = '0;
              end else begin
                cursor_nxt = (cur_inc == IW'(LINE_CHARS - 1)) ? '0 : cur_inc;
              end
            end
          end
          default: begin
            cmd_nxt = cmd_r;
          end
        endcase
      end
      B_RAW_SEND: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_kind = KIND_DATA;
          emit_byte = rram_rd_data;
          emit_last = 1'b1;
          rp_nxt    = rp_inc;
        end
      end
      B_LINE_SEND: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_kind = KIND_DATA;
          emit_byte = lram_rd_data;
          emit_last = line_last;
          if (line_last) begin
            valid_nxt[lb] = '0;
          end else begin
            lram_rd_en = 1'b1;
            idx_nxt    = idx_inc;
          end
        end
      end
      B_ERASE_SEND: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_byte = erase_char(ecnt_r);
          emit_last = erase_last;
          ecnt_nxt  = 3'(ecnt_r + 1'b1);
        end
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase

    if (cfg_wr) begin
      raw_en_nxt = cfg_raw;
      if (cfg_raw) begin
        valid_nxt  = '0;
        cursor_nxt = '0;
        wp_nxt     = '0;
        rp_nxt     = '0;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = emit_kind;
      out_byte_nxt  = emit_byte;
      out_last_nxt  = emit_last;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      cursor_r    <= '0;
      bank_r      <= 1'b0;
      valid_r     <= '0;
      wp_r        <= '0;
      rp_r        <= '0;
      raw_en_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      bank_r      <= bank_nxt;
      valid_r     <= valid_nxt;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      raw_en_r    <= raw_en_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r      <= cmd_nxt;
    byte_r     <= byte_nxt;
    idx_r      <= idx_nxt;
    ecnt_r     <= ecnt_nxt;
    out_kind_r <= out_kind_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign raw_en     = raw_en_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

// ===== rtl/uart_line_discipline.sv =====
// Flow: an accepted item is written into the command queue, popped into the command
// register when the executer is idle, decoded, and its first result is registered into the
// output register; a raw or line read of stored data adds a registered memory read.
// The executer takes one queued item at a time and returns to idle before popping another;
// a line read streams one byte per cycle and an erase one echo per cycle while out_tready holds.
// Reset: synchronous, clears mode, cursor, pointers and all line valid bits; no memory pass.
`default_nettype none

module uart_line_discipline
  import uld_pkg::*;
#(
  parameter int LINE_CHARS = LINE_CHARS_DEF,
  parameter int RAW_DEPTH  = RAW_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // rx_byte[7:0]
  input  wire logic [0:0] in_tuser,   // op[0]
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // out_byte[7:0]
  output logic [1:0]      out_tuser,  // kind[1:0]
  output logic            out_tlast,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [0:0] cfg_data
);

  logic     raw_en;
  logic     q_full, q_push, q_pop, q_valid;
  q_entry_t q_entry, q_head;

  assign cfg_ready = 1'b1;

  uld_front u_front (
    .raw_en    (raw_en),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  uld_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_valid),
    .head       (q_head)
  );

  uld_back #(
    .LINE_CHARS (LINE_CHARS),
    .RAW_DEPTH  (RAW_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr     (cfg_valid),
    .cfg_raw    (cfg_data[0]),
    .raw_en     (raw_en),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire
